// ----- rtl/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, sizes and codes for the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int FILL_W  = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY_POP = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        logic [STAT_W-1:0]        status;
    } t_result;

endpackage

// ----- rtl/mts_if.sv -----
// ----------------------------------------------------------------------------
// mts_if
// Valid/ready channels for commands and results of the min-tracking stack.
// ----------------------------------------------------------------------------
interface mts_cmd_if import mts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface mts_res_if import mts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output top_value, output min_value,
                    output fill_count, output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input min_value,
                    input fill_count, input is_empty, input status, output ready);
endinterface

// ----- rtl/min_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack
// Stack of signed 32-bit values reporting top, running minimum and fill.
//
//   channel    dir  payload                                        handshake
//   i_cmd_ch   in   cmd, push_value                                valid/ready
//   o_res_ch   out  top_value, min_value, fill_count, is_empty,    valid/ready
//                   status
//
// One item per cycle unless stalled; its result is valid in the next cycle.
// The top entry and its minimum live in registers; lower entries sit in a
// registered-read RAM whose next entry is prefetched every cycle.
// Reset (synchronous, active low) empties the stack; no RAM clearing.
// A stalled result holds the command channel until the result is taken.
// ----------------------------------------------------------------------------
module min_tracking_stack import mts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_cmd_if.sink   i_cmd_ch,
    mts_res_if.source o_res_ch
);

    logic    r_out_valid, n_out_valid;
    t_result r_res;
    t_result core_res;
    logic    accept;

    // accept when the result register is free or being drained
    assign i_cmd_ch.ready = !r_out_valid || o_res_ch.ready;
    assign accept         = i_cmd_ch.valid && i_cmd_ch.ready;

    mts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd_ch.cmd),
        .i_push_value (i_cmd_ch.push_value),
        .o_result     (core_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_res_ch.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        // load the result of every accepted item
        if (accept) begin
            r_res <= core_res;
        end
    end

    assign o_res_ch.valid      = r_out_valid;
    assign o_res_ch.top_value  = r_res.top_value;
    assign o_res_ch.min_value  = r_res.min_value;
    assign o_res_ch.fill_count = r_res.fill_count;
    assign o_res_ch.is_empty   = r_res.is_empty;
    assign o_res_ch.status     = r_res.status;

endmodule

// ----- rtl/mts_ram.sv -----
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mts_core.sv -----
// ----------------------------------------------------------------------------
// mts_core
// Stack state: top entry in registers, lower entries in RAM, with the
// second entry prefetched so a pop does not wait for a RAM read.
// ----------------------------------------------------------------------------
module mts_core import mts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_push_value,
    output t_result                  o_result
);

    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic                     r_fwd, n_fwd;
    logic [ENTRY_W-1:0]       r_fwd_data;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr;
    logic [ENTRY_W-1:0]       wdata;
    logic [ENTRY_W-1:0]       rdata;
    logic [ENTRY_W-1:0]       second;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         ncnt_m2;

    // entry below the top: straight from RAM unless written last cycle
    assign second = r_fwd ? r_fwd_data : rdata;
    assign cnt_m1 = r_count - CNT_W'(1);
    assign waddr  = cnt_m1[ADDR_W-1:0];
    assign wdata  = {r_top_val, r_top_min};

    always_comb begin
        n_count   = r_count;
        n_top_val = r_top_val;
        n_top_min = r_top_min;
        we        = 1'b0;
        status    = STAT_OK;
        if (i_accept) begin
            case (i_cmd)
                CMD_PUSH: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        status = STAT_FULL;
                    end else begin
                        // spill the old top below the new one
                        we        = (r_count != '0);
                        n_top_val = i_push_value;
                        n_top_min = ((r_count != '0) && (r_top_min < i_push_value))
                                    ? r_top_min : i_push_value;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                CMD_POP: begin
                    if (r_count == '0) begin
                        status = STAT_EMPTY_POP;
                    end else begin
                        n_count = cnt_m1;
                        if (r_count == CNT_W'(1)) begin
                            n_top_val = '0;
                            n_top_min = INT_MAX;
                        end else begin
                            n_top_val = second[ENTRY_W-1:DATA_W];
                            n_top_min = second[DATA_W-1:0];
                        end
                    end
                end
                default: begin
                    status = STAT_OK;
                end
            endcase
        end
    end

    // prefetch the entry that sits below the next top
    assign ncnt_m2 = n_count - CNT_W'(2);
    assign raddr   = ncnt_m2[ADDR_W-1:0];
    assign n_fwd   = we && (waddr == raddr);

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_top_val <= '0;
            r_top_min <= INT_MAX;
            r_fwd     <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_top_val <= n_top_val;
            r_top_min <= n_top_min;
            r_fwd     <= n_fwd;
        end
        r_fwd_data <= wdata;
    end

    always_comb begin
        o_result.top_value  = n_top_val;
        o_result.min_value  = n_top_min;
        o_result.fill_count = FILL_W'(n_count);
        o_result.is_empty   = (n_count == '0);
        o_result.status     = status;
    end

endmodule

// ----- rtl/mts_checker.sv -----
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks for the min-tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker import mts_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] i_top_value,
    input logic signed [DATA_W-1:0] i_min_value,
    input logic [FILL_W-1:0]        i_fill_count,
    input logic                     i_is_empty,
    input logic [STAT_W-1:0]        i_status
);

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_empty) |-> (i_top_value == '0 && i_min_value == INT_MAX))
        else $error("empty result with wrong top or minimum");

    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_is_empty) |-> (i_min_value <= i_top_value))
        else $error("minimum above top value");

    a_refused_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == STAT_EMPTY_POP) |-> (i_is_empty && i_fill_count == '0))
        else $error("pop refused on non-empty stack");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_top_value)
                                            && $stable(i_min_value) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res_ch.valid),
    .i_out_ready  (o_res_ch.ready),
    .i_top_value  (o_res_ch.top_value),
    .i_min_value  (o_res_ch.min_value),
    .i_fill_count (o_res_ch.fill_count),
    .i_is_empty   (o_res_ch.is_empty),
    .i_status     (o_res_ch.status)
);
